>>> rtl/core/joystick_crawler_flipper_mixer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the joystick crawler flipper mixer
// Clocked property wrappers for the top-level file that carries the assertions.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_CRAWLER_FLIPPER_MIXER_MACROS_SVH
`define JOYSTICK_CRAWLER_FLIPPER_MIXER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define JCFM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jcfm assertion failed");

// Consequent must hold in the cycle after the antecedent
`define JCFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jcfm assertion failed");

`endif

>>> rtl/core/jcfm_pkg.sv
// ----------------------------------------------------------------------------
// jcfm_pkg
// Shared types, register map and constants of the crawler/flipper mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jcfm_pkg;

  // Register map: byte address 4*index
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_CRAWLER_FULL = 3'd0;
  localparam logic [2:0] REG_FLIPPER_FULL = 3'd1;
  localparam logic [2:0] REG_FLIPPER_STEP = 3'd2;
  localparam logic [2:0] REG_DEAD_ZONE    = 3'd3;
  localparam logic [2:0] REG_SLOW_GAIN    = 3'd4;
  localparam logic [2:0] REG_NORMAL_GAIN  = 3'd5;
  localparam logic [2:0] REG_STOP_KEY     = 3'd6;
  localparam logic [2:0] REG_RELEASE_KEY  = 3'd7;

  // Reset values of the registers
  localparam logic [14:0] RST_CRAWLER_FULL = 15'd14000;
  localparam logic [14:0] RST_FLIPPER_FULL = 15'd7200;
  localparam logic [14:0] RST_FLIPPER_STEP = 15'd1440;
  localparam logic [14:0] RST_DEAD_ZONE    = 15'd328;
  localparam logic [15:0] RST_SLOW_GAIN    = 16'd9830;
  localparam logic [15:0] RST_NORMAL_GAIN  = 16'd19661;
  localparam logic [31:0] RST_STOP_KEY     = 32'd111;
  localparam logic [31:0] RST_RELEASE_KEY  = 32'd112;

  // Q1.15 unity gain and command magnitude limit
  localparam logic [15:0] GAIN_ONE = 16'h8000;
  localparam logic [14:0] CMD_MAX  = 15'h7fff;

  // Item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_KEY    = 1'b1;

  // Button bit positions
  localparam int BTN_L3       = 0;
  localparam int BTN_R3       = 1;
  localparam int BTN_CIRCLE   = 2;
  localparam int BTN_SQUARE   = 3;
  localparam int BTN_FLIP0    = 4;
  localparam int BTN_CROSS    = 8;
  localparam int BTN_TRIANGLE = 9;
  localparam int NUM_FLIPPERS = 4;

  typedef struct packed {
    logic [14:0]        crawler_full_speed;
    logic [14:0]        flipper_full_speed;
    logic [14:0]        flipper_step;
    logic [14:0]        dead_zone;
    logic [15:0]        slow_gain;
    logic [15:0]        normal_gain;
    logic signed [31:0] stop_key;
    logic signed [31:0] release_key;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_R,
    ST_MUL_L,
    ST_GAIN_R,
    ST_GAIN_L,
    ST_COMMIT,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic mul_r;
    logic mul_l;
    logic gain_r;
    logic gain_l;
    logic commit_sample;
    logic emit_key;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic key_item;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/jcfm_ifs.sv
// ----------------------------------------------------------------------------
// jcfm channel interfaces
// Valid/ready channels for gamepad words and motor command words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jcfm_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] stick_up_down;
  logic signed [15:0] stick_left_right;
  logic [9:0]         buttons;
  logic signed [31:0] key_code;

  modport source (output valid, mode, stick_up_down, stick_left_right, buttons, key_code,
                  input ready);
  modport sink (input valid, mode, stick_up_down, stick_left_right, buttons, key_code,
                output ready);
endinterface

interface jcfm_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] crawler_right_speed;
  logic signed [15:0] crawler_left_speed;
  logic signed [15:0] front_right_flipper;
  logic signed [15:0] front_left_flipper;
  logic signed [15:0] rear_right_flipper;
  logic signed [15:0] rear_left_flipper;
  logic               stop_active;
  logic               drive_mode_on;

  modport source (output valid, crawler_right_speed, crawler_left_speed,
                  front_right_flipper, front_left_flipper, rear_right_flipper,
                  rear_left_flipper, stop_active, drive_mode_on,
                  input ready);
  modport sink (input valid, crawler_right_speed, crawler_left_speed,
                front_right_flipper, front_left_flipper, rear_right_flipper,
                rear_left_flipper, stop_active, drive_mode_on,
                output ready);
endinterface

>>> rtl/core/jcfm_regs.sv
// ----------------------------------------------------------------------------
// jcfm_regs
// APB-style configuration register file with read-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcfm_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jcfm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output jcfm_pkg::cfg_t               cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[jcfm_pkg::ADDR_W-1:2];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crawler_full_speed <= jcfm_pkg::RST_CRAWLER_FULL;
      cfg.flipper_full_speed <= jcfm_pkg::RST_FLIPPER_FULL;
      cfg.flipper_step       <= jcfm_pkg::RST_FLIPPER_STEP;
      cfg.dead_zone          <= jcfm_pkg::RST_DEAD_ZONE;
      cfg.slow_gain          <= jcfm_pkg::RST_SLOW_GAIN;
      cfg.normal_gain        <= jcfm_pkg::RST_NORMAL_GAIN;
      cfg.stop_key           <= jcfm_pkg::RST_STOP_KEY;
      cfg.release_key        <= jcfm_pkg::RST_RELEASE_KEY;
    end else if (wr) begin
      case (idx)
        jcfm_pkg::REG_CRAWLER_FULL: cfg.crawler_full_speed <= pwdata[14:0];
        jcfm_pkg::REG_FLIPPER_FULL: cfg.flipper_full_speed <= pwdata[14:0];
        jcfm_pkg::REG_FLIPPER_STEP: cfg.flipper_step       <= pwdata[14:0];
        jcfm_pkg::REG_DEAD_ZONE:    cfg.dead_zone          <= pwdata[14:0];
        jcfm_pkg::REG_SLOW_GAIN:    cfg.slow_gain          <= pwdata[15:0];
        jcfm_pkg::REG_NORMAL_GAIN:  cfg.normal_gain        <= pwdata[15:0];
        jcfm_pkg::REG_STOP_KEY:     cfg.stop_key           <= pwdata;
        jcfm_pkg::REG_RELEASE_KEY:  cfg.release_key        <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      jcfm_pkg::REG_CRAWLER_FULL: prdata = {17'd0, cfg.crawler_full_speed};
      jcfm_pkg::REG_FLIPPER_FULL: prdata = {17'd0, cfg.flipper_full_speed};
      jcfm_pkg::REG_FLIPPER_STEP: prdata = {17'd0, cfg.flipper_step};
      jcfm_pkg::REG_DEAD_ZONE:    prdata = {17'd0, cfg.dead_zone};
      jcfm_pkg::REG_SLOW_GAIN:    prdata = {16'd0, cfg.slow_gain};
      jcfm_pkg::REG_NORMAL_GAIN:  prdata = {16'd0, cfg.normal_gain};
      jcfm_pkg::REG_STOP_KEY:     prdata = cfg.stop_key;
      jcfm_pkg::REG_RELEASE_KEY:  prdata = cfg.release_key;
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/jcfm_ctrl.sv
// ----------------------------------------------------------------------------
// jcfm_ctrl
// Sequencer: input handshake and the four passes of the shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcfm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  jcfm_pkg::status_t  status,
  output jcfm_pkg::cmd_t     cmd
);

  jcfm_pkg::state_t state;
  jcfm_pkg::state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jcfm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance through the passes and issue commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      jcfm_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = status.key_item ? jcfm_pkg::ST_EMIT : jcfm_pkg::ST_MUL_R;
        end
      end
      jcfm_pkg::ST_MUL_R: begin
        cmd.mul_r  = 1'b1;
        state_next = jcfm_pkg::ST_MUL_L;
      end
      jcfm_pkg::ST_MUL_L: begin
        cmd.mul_l  = 1'b1;
        state_next = jcfm_pkg::ST_GAIN_R;
      end
      jcfm_pkg::ST_GAIN_R: begin
        cmd.gain_r = 1'b1;
        state_next = jcfm_pkg::ST_GAIN_L;
      end
      jcfm_pkg::ST_GAIN_L: begin
        cmd.gain_l = 1'b1;
        state_next = jcfm_pkg::ST_COMMIT;
      end
      jcfm_pkg::ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit_sample = 1'b1;
          state_next        = jcfm_pkg::ST_IDLE;
        end
      end
      jcfm_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_key = 1'b1;
          state_next   = jcfm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = jcfm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/jcfm_dp.sv
// ----------------------------------------------------------------------------
// jcfm_dp
// Datapath: mode and stop state, tank mixing on one shared multiplier,
// flipper ramps and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcfm_dp (
  input  logic               clk,
  input  logic               rst,
  input  jcfm_pkg::cfg_t     cfg,
  input  jcfm_pkg::cmd_t     cmd,
  output jcfm_pkg::status_t  status,
  input  logic               mode,
  input  logic signed [15:0] stick_up_down,
  input  logic signed [15:0] stick_left_right,
  input  logic [9:0]         buttons,
  input  logic signed [31:0] key_code,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [15:0] crawler_right_speed,
  output logic signed [15:0] crawler_left_speed,
  output logic signed [15:0] front_right_flipper,
  output logic signed [15:0] front_left_flipper,
  output logic signed [15:0] rear_right_flipper,
  output logic signed [15:0] rear_left_flipper,
  output logic               stop_active,
  output logic               drive_mode_on
);

  localparam int NF = jcfm_pkg::NUM_FLIPPERS;

  // Held model state
  logic               crawler_enabled;
  logic               stop_latched;
  logic signed [15:0] flip [NF];
  logic signed [15:0] crawl_r;
  logic signed [15:0] crawl_l;

  // Per-item work registers
  logic [9:0]  btn;
  logic [16:0] mag_r;
  logic [16:0] mag_l;
  logic        neg_r;
  logic        neg_l;
  logic [32:0] prod;
  logic [14:0] term_r;
  logic [14:0] term_l;
  logic [14:0] res_r;

  // Combinational helpers
  logic [16:0] sum_r;
  logic [16:0] sum_l;
  logic [15:0] abs_y;
  logic [15:0] abs_x;
  logic        live;
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] mul_p;
  logic [17:0] prod_q;
  logic [14:0] clamped;
  logic [14:0] saturated;
  logic [15:0] gain;
  logic        blocked;
  logic signed [15:0] right_val;
  logic signed [15:0] left_val;
  logic signed [17:0] fv   [NF];
  logic signed [17:0] fabs [NF];
  logic signed [15:0] flip_next [NF];
  logic signed [17:0] lim18;
  logic signed [17:0] st18;

  assign status.key_item = (mode == jcfm_pkg::MODE_KEY);
  assign status.out_free = !res_valid || res_ready;

  // Mix the stick: sums, magnitudes and dead zone test
  assign sum_r = {stick_up_down[15], stick_up_down} + {stick_left_right[15], stick_left_right};
  assign sum_l = {stick_up_down[15], stick_up_down} - {stick_left_right[15], stick_left_right};
  assign abs_y = stick_up_down[15] ? 16'(-stick_up_down) : 16'(stick_up_down);
  assign abs_x = stick_left_right[15] ? 16'(-stick_left_right) : 16'(stick_left_right);
  assign live  = (abs_y > {1'b0, cfg.dead_zone}) || (abs_x > {1'b0, cfg.dead_zone});

  // Pick the gain: square beats circle
  always_comb begin
    if (btn[jcfm_pkg::BTN_SQUARE]) begin
      gain = cfg.slow_gain;
    end else if (btn[jcfm_pkg::BTN_CIRCLE]) begin
      gain = jcfm_pkg::GAIN_ONE;
    end else begin
      gain = cfg.normal_gain;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = mag_r;
    mul_b = {1'b0, cfg.crawler_full_speed};
    if (cmd.mul_l) begin
      mul_a = mag_l;
    end else if (cmd.gain_r) begin
      mul_a = {2'b00, term_r};
      mul_b = gain;
    end else if (cmd.gain_l) begin
      mul_a = {2'b00, term_l};
      mul_b = gain;
    end
  end

  assign mul_p  = 33'(mul_a) * 33'(mul_b);
  assign prod_q = prod[32:15];

  // Clamp to full speed, saturate to the command limit
  assign clamped   = (prod_q > {3'b000, cfg.crawler_full_speed}) ? cfg.crawler_full_speed
                                                                : prod_q[14:0];
  assign saturated = (prod_q > {3'b000, jcfm_pkg::CMD_MAX}) ? jcfm_pkg::CMD_MAX
                                                           : prod_q[14:0];

  // Right is stored negated, so its sign flips
  assign right_val = neg_r ? $signed({1'b0, res_r}) : -$signed({1'b0, res_r});
  assign left_val  = neg_l ? -$signed({1'b0, saturated}) : $signed({1'b0, saturated});
  assign blocked   = stop_latched || !crawler_enabled;

  // Ramp each flipper lane; cross beats triangle
  assign lim18 = $signed({3'b000, cfg.flipper_full_speed});
  assign st18  = $signed({3'b000, cfg.flipper_step});

  always_comb begin
    for (int i = 0; i < NF; i++) begin
      fv[i] = btn[jcfm_pkg::BTN_FLIP0 + i] ? 18'(flip[i]) : 18'sd0;
      if (btn[jcfm_pkg::BTN_CROSS]) begin
        if (btn[jcfm_pkg::BTN_FLIP0 + i]) begin
          fv[i] = fv[i] + st18;
        end
      end else if (btn[jcfm_pkg::BTN_TRIANGLE]) begin
        if (btn[jcfm_pkg::BTN_FLIP0 + i]) begin
          fv[i] = fv[i] - st18;
        end
      end else begin
        fv[i] = 18'sd0;
      end
      fabs[i] = fv[i][17] ? -fv[i] : fv[i];
      if (fabs[i] > lim18) begin
        fv[i] = btn[jcfm_pkg::BTN_CROSS] ? lim18 : -lim18;
      end
      flip_next[i] = fv[i][15:0];
    end
  end

  // Take the item: latch stick terms, update mode and stop
  always_ff @(posedge clk) begin
    if (rst) begin
      crawler_enabled <= 1'b1;
      stop_latched    <= 1'b0;
    end else if (cmd.accept) begin
      if (mode == jcfm_pkg::MODE_KEY) begin
        if (key_code == cfg.stop_key) begin
          stop_latched <= 1'b1;
        end else if (key_code == cfg.release_key) begin
          stop_latched <= 1'b0;
        end
      end else if (buttons[jcfm_pkg::BTN_R3]) begin
        crawler_enabled <= 1'b0;
      end else if (buttons[jcfm_pkg::BTN_L3]) begin
        crawler_enabled <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      btn   <= buttons;
      mag_r <= !live ? 17'd0 : (sum_r[16] ? 17'(-sum_r) : sum_r);
      mag_l <= !live ? 17'd0 : (sum_l[16] ? 17'(-sum_l) : sum_l);
      neg_r <= sum_r[16];
      neg_l <= sum_l[16];
    end
  end

  // Run the four multiplier passes
  always_ff @(posedge clk) begin
    if (cmd.mul_r || cmd.mul_l || cmd.gain_r || cmd.gain_l) begin
      prod <= mul_p;
    end
    if (cmd.mul_l) begin
      term_r <= clamped;
    end
    if (cmd.gain_r) begin
      term_l <= clamped;
    end
    if (cmd.gain_l) begin
      res_r <= saturated;
    end
  end

  // Commit the motor commands
  always_ff @(posedge clk) begin
    if (rst) begin
      crawl_r <= '0;
      crawl_l <= '0;
      for (int i = 0; i < NF; i++) begin
        flip[i] <= '0;
      end
    end else if (cmd.commit_sample) begin
      crawl_r <= blocked ? 16'sd0 : right_val;
      crawl_l <= blocked ? 16'sd0 : left_val;
      for (int i = 0; i < NF; i++) begin
        flip[i] <= blocked ? 16'sd0 : flip_next[i];
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit_sample || cmd.emit_key) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_sample) begin
      crawler_right_speed <= blocked ? 16'sd0 : right_val;
      crawler_left_speed  <= blocked ? 16'sd0 : left_val;
      front_right_flipper <= blocked ? 16'sd0 : flip_next[0];
      front_left_flipper  <= blocked ? 16'sd0 : flip_next[1];
      rear_right_flipper  <= blocked ? 16'sd0 : flip_next[2];
      rear_left_flipper   <= blocked ? 16'sd0 : flip_next[3];
      stop_active         <= stop_latched;
      drive_mode_on       <= crawler_enabled;
    end else if (cmd.emit_key) begin
      crawler_right_speed <= crawl_r;
      crawler_left_speed  <= crawl_l;
      front_right_flipper <= flip[0];
      front_left_flipper  <= flip[1];
      rear_right_flipper  <= flip[2];
      rear_left_flipper   <= flip[3];
      stop_active         <= stop_latched;
      drive_mode_on       <= crawler_enabled;
    end
  end

endmodule

>>> rtl/core/joystick_crawler_flipper_mixer.sv
// ----------------------------------------------------------------------------
// joystick_crawler_flipper_mixer
// Gamepad words in, six motor speed commands and two status flags out.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready channel of gamepad words (controller samples and
//            key events, chosen by mode).
//   result : valid/ready channel, one command word for every item taken.
//   APB    : eight configuration registers at byte address 4*index; write
//            only while the block is idle.
// Timing: a controller sample's word takes four passes through the single
//   shared 17x16 multiplier, then a commit into the output register; a key
//   event's word is loaded from the held commands in the emit state.
//   The next item is accepted on the cycle after the commit, so a new item
//   is taken only once the last one is committed or emitted.
// Reset: crawler mode on, stop clear, all commands zero, registers at their
//   default values; the result register comes up empty.
// Stall: a finished word waits in the output register; a further item can
//   be accepted and worked on, and its commit holds until the register is
//   taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "joystick_crawler_flipper_mixer_macros.svh"

module joystick_crawler_flipper_mixer (
  input  logic                         clk,
  input  logic                         rst,
  jcfm_item_if.sink                    item,
  jcfm_result_if.source                result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jcfm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  jcfm_pkg::cfg_t    cfg;
  jcfm_pkg::cmd_t    cmd;
  jcfm_pkg::status_t status;
  logic              item_ready;

  assign item.ready = item_ready;

  jcfm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jcfm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  jcfm_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .status              (status),
    .mode                (item.mode),
    .stick_up_down       (item.stick_up_down),
    .stick_left_right    (item.stick_left_right),
    .buttons             (item.buttons),
    .key_code            (item.key_code),
    .res_valid           (result.valid),
    .res_ready           (result.ready),
    .crawler_right_speed (result.crawler_right_speed),
    .crawler_left_speed  (result.crawler_left_speed),
    .front_right_flipper (result.front_right_flipper),
    .front_left_flipper  (result.front_left_flipper),
    .rear_right_flipper  (result.rear_right_flipper),
    .rear_left_flipper   (result.rear_left_flipper),
    .stop_active         (result.stop_active),
    .drive_mode_on       (result.drive_mode_on)
  );

  // One item at a time: the port closes right after a word is taken
  `JCFM_ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item_ready, !item_ready)
  // A word is loaded only when the output register is free
  `JCFM_ASSERT_SAME(a_load_when_free, clk, rst, cmd.commit_sample || cmd.emit_key, !result.valid || result.ready)
  // The controller issues at most one command per cycle
  `JCFM_ASSERT_SAME(a_one_command, clk, rst, 1'b1, $onehot0(cmd))
  // Crawler commands never reach the most negative code
  `JCFM_ASSERT_SAME(a_crawler_range, clk, rst, result.valid, result.crawler_right_speed != 16'sh8000 && result.crawler_left_speed != 16'sh8000)

endmodule
